### hdl/lr_pkg.sv
`default_nettype none

package lr_pkg;

  // default coordinate width and fixed colour width
  localparam int LR_COORD_BITS = 6;
  localparam int COLOUR_BITS   = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a line command
    logic setup;  // derive deltas, start point and error term
    logic step;   // emit one pixel and advance along the major axis
  } lr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic final_step;  // pixel being emitted now is the end of the line
  } lr_status_t;

endpackage

`default_nettype wire

### hdl/line_rasterizer_core.sv
// Bresenham line rasterizer. A command (two endpoints and a colour) is taken
// on a clock edge with start high and busy low. The block then derives the
// deltas, start point and error term in its setup state, and emits one pixel
// per cycle along the major axis, each marked by pixel_valid for exactly one
// cycle; the receiver cannot stall the stream and must take every transfer.
// A line with major-axis length n gives n+1 pixels, the last one flagged by
// last_pixel. From the accepting edge, busy stays high through the setup and
// stepping states. The next command may be accepted while the last pixel is
// on the ports.

`default_nettype none

module line_rasterizer_core #(
  parameter int COORD_BITS = lr_pkg::LR_COORD_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [COORD_BITS-1:0]           start_x,
  input  wire logic [COORD_BITS-1:0]           start_y,
  input  wire logic [COORD_BITS-1:0]           end_x,
  input  wire logic [COORD_BITS-1:0]           end_y,
  input  wire logic [lr_pkg::COLOUR_BITS-1:0]  colour,
  output logic                                 pixel_valid,
  output logic [COORD_BITS-1:0]                pixel_x,
  output logic [COORD_BITS-1:0]                pixel_y,
  output logic [lr_pkg::COLOUR_BITS-1:0]       pixel_colour,
  output logic                                 last_pixel
);
  import lr_pkg::*;

  lr_cmd_t    cmd;
  lr_status_t status;

  // sequencing
  lr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // setup and stepping arithmetic
  lr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .colour       (colour),
    .pixel_valid  (pixel_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_colour (pixel_colour),
    .last_pixel   (last_pixel)
  );

endmodule

`default_nettype wire

### hdl/lr_ctrl.sv
`default_nettype none

module lr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  lr_pkg::lr_status_t      status,
  output lr_pkg::lr_cmd_t         cmd,
  output logic                    busy
);
  import lr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } lr_state_t;

  lr_state_t state;
  lr_state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.final_step) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command decode
  always_comb begin
    cmd.load  = (state == ST_IDLE) && start;
    cmd.setup = (state == ST_SETUP);
    cmd.step  = (state == ST_RUN);
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

### hdl/lr_datapath.sv
`default_nettype none

module lr_datapath #(
  parameter int COORD_BITS = lr_pkg::LR_COORD_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  lr_pkg::lr_cmd_t                      cmd,
  output lr_pkg::lr_status_t                   status,
  input  wire logic [COORD_BITS-1:0]           start_x,
  input  wire logic [COORD_BITS-1:0]           start_y,
  input  wire logic [COORD_BITS-1:0]           end_x,
  input  wire logic [COORD_BITS-1:0]           end_y,
  input  wire logic [lr_pkg::COLOUR_BITS-1:0]  colour,
  output logic                                 pixel_valid,
  output logic [COORD_BITS-1:0]                pixel_x,
  output logic [COORD_BITS-1:0]                pixel_y,
  output logic [lr_pkg::COLOUR_BITS-1:0]       pixel_colour,
  output logic                                 last_pixel
);
  import lr_pkg::*;

  localparam int N = COORD_BITS;
  localparam int E = COORD_BITS + 3;  // error term width, signed

  // captured command
  logic [N-1:0]           sx, sy, ex, ey;
  logic [COLOUR_BITS-1:0] colour_q;

  // stepping state
  logic [N-1:0]        cur_x, cur_y;
  logic [N-1:0]        remain;
  logic signed [E-1:0] err;
  logic signed [E-1:0] inc_keep;
  logic signed [E-1:0] inc_step;
  logic                x_major;
  logic                dir_pos;

  // setup arithmetic
  logic signed [N:0] dx, dy;
  logic [N:0]        dx_neg, dy_neg;
  logic [N-1:0]      adx, ady;
  logic [N-1:0]      major, minor;
  logic              major_x;
  logic              dir_up;
  logic [N-1:0]      init_x, init_y;
  logic [E-1:0]      minor2, major2;

  always_comb begin
    dx      = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy      = $signed({1'b0, ey}) - $signed({1'b0, sy});
    dx_neg  = -dx;
    dy_neg  = -dy;
    adx     = dx[N] ? dx_neg[N-1:0] : dx[N-1:0];
    ady     = dy[N] ? dy_neg[N-1:0] : dy[N-1:0];
    major_x = (ady <= adx);
    // minor moves up when both deltas share a strict sign
    dir_up  = (!dx[N] && (dx != '0) && !dy[N] && (dy != '0)) || (dx[N] && dy[N]);
    major   = major_x ? adx : ady;
    minor   = major_x ? ady : adx;
    // run starts at the smaller end of the major axis
    if (major_x ? dx[N] : dy[N]) begin
      init_x = ex;
      init_y = ey;
    end else begin
      init_x = sx;
      init_y = sy;
    end
    minor2 = {2'b00, minor, 1'b0};
    major2 = {2'b00, major, 1'b0};
  end

  // minor-axis step decision
  logic         minor_go;
  logic [N-1:0] minor_cur, minor_moved;

  always_comb begin
    if (x_major) begin
      minor_go = !err[E-1];
    end else begin
      minor_go = !err[E-1] && (err != '0);
    end
    minor_cur   = x_major ? cur_y : cur_x;
    minor_moved = dir_pos ? minor_cur + N'(1) : minor_cur - N'(1);
  end

  assign status.final_step = (remain == '0);

  // command capture, setup and stepping registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx       <= start_x;
      sy       <= start_y;
      ex       <= end_x;
      ey       <= end_y;
      colour_q <= colour;
    end
    if (cmd.setup) begin
      cur_x    <= init_x;
      cur_y    <= init_y;
      remain   <= major;
      x_major  <= major_x;
      dir_pos  <= dir_up;
      err      <= $signed(minor2) - $signed({3'b000, major});
      inc_keep <= $signed(minor2);
      inc_step <= $signed(minor2) - $signed(major2);
    end
    if (cmd.step) begin
      remain <= remain - N'(1);
      if (x_major) begin
        cur_x <= cur_x + N'(1);
        if (minor_go) cur_y <= minor_moved;
      end else begin
        cur_y <= cur_y + N'(1);
        if (minor_go) cur_x <= minor_moved;
      end
      err <= minor_go ? err + inc_step : err + inc_keep;
    end
  end

  // result register, one transfer per step
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      last_pixel  <= 1'b0;
    end else begin
      pixel_valid <= cmd.step;
      last_pixel  <= cmd.step && status.final_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x      <= cur_x;
      pixel_y      <= cur_y;
      pixel_colour <= colour_q;
    end
  end

endmodule

`default_nettype wire

### hdl/lr_checker.sv
`default_nettype none

module lr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            pixel_valid,
  input wire logic [lr_pkg::COLOUR_BITS-1:0]  pixel_colour,
  input wire logic                            last_pixel
);

  // an accepted command keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // end-of-line flag only rides on a pixel transfer
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last_pixel |-> pixel_valid)
    else $error("last_pixel without pixel_valid");

  // a line streams without gaps and stays busy until its last pixel
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !last_pixel) |-> (busy ##1 pixel_valid))
    else $error("gap inside a line");

  // colour is constant along a line
  a_colour_steady: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !last_pixel) |=> $stable(pixel_colour))
    else $error("pixel colour changed inside a line");

  // nothing is emitted right after the last pixel
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && last_pixel) |=> !pixel_valid)
    else $error("pixel after end of line");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (.*);

`default_nettype wire
